[sv/pfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants for the page frame allocator
// Beat structs, register indexes, mode, source and fill codes.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int NUM_FRAMES = 32;
  localparam int FRAME_BITS = $clog2(NUM_FRAMES);
  localparam int VPN_BITS   = 12;
  localparam int PID_BITS   = 8;
  localparam int OFFS_BITS  = 24;
  localparam int SEED_BITS  = 16;

  localparam logic [SEED_BITS-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [SEED_BITS-1:0] LFSR_ONE  = 16'h0001;

  // configuration register indexes
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_SEED = 1'b1;

  // replacement modes (code 3 acts as no replacement)
  localparam logic [1:0] MODE_FIFO   = 2'd0;
  localparam logic [1:0] MODE_RANDOM = 2'd1;
  localparam logic [1:0] MODE_NONE   = 2'd2;

  localparam logic OP_FAULT = 1'b0;
  localparam logic OP_DIRTY = 1'b1;

  localparam logic [1:0] SRC_EXEC = 2'd0;
  localparam logic [1:0] SRC_SWAP = 2'd1;

  localparam logic [1:0] FILL_EXEC = 2'd0;
  localparam logic [1:0] FILL_SWAP = 2'd1;
  localparam logic [1:0] FILL_ZERO = 2'd2;

  typedef struct packed {
    logic                  op;
    logic [VPN_BITS-1:0]   virtual_page;
    logic [PID_BITS-1:0]   process_id;
    logic [1:0]            page_source;
    logic [OFFS_BITS-1:0]  file_offset;
    logic [FRAME_BITS-1:0] target_frame;
  } pfa_req_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic                  evicted;
    logic [VPN_BITS-1:0]   evicted_page;
    logic [PID_BITS-1:0]   evicted_owner;
    logic                  evicted_dirty;
    logic [1:0]            fill_kind;
    logic [OFFS_BITS-1:0]  fill_offset;
    logic                  status;
  } pfa_res_t;

  // one inverted page table entry as kept in memory
  typedef struct packed {
    logic [VPN_BITS-1:0] vpn;
    logic [PID_BITS-1:0] owner;
  } pfa_entry_t;

endpackage

[sv/pfa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/page_frame_allocator_fifo_random.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_allocator_fifo_random: page fault frame allocator
// Inverted page table with FIFO or LFSR victim choice on a full table.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive in_req and raise start; the beat is taken at an
//   edge where start is high and busy is low. op 0 is a page fault, op 1
//   marks a frame dirty.
//   Result channel: every request yields exactly one result beat on out_res,
//   flagged by out_valid for a single cycle. The receiver cannot stall, so
//   the result must be captured in that cycle.
//   Config channel: cfg_index/cfg_data with cfg_valid; cfg_ready is always
//   high. Index 0 is the replacement mode, index 1 reloads the LFSR seed
//   (zero loads 1). Write only while no request is outstanding.
// Timing:
//   Accept edge -> FIND state -> OUT state -> out_valid register, so the
//   result reaches the ports once out_valid is registered. busy is high
//   only in FIND, so a new request can already be taken in OUT, before the
//   previous result is on the ports. FIND and OUT are separate because the
//   FIFO order memory and the page table memory, whose read address is the
//   chosen frame, both have registered read data.
// Reset (rst_n low, synchronous): all frames free and invalid, FIFO queue
//   empty, mode FIFO, LFSR = 1. The table memory needs no clearing pass: a
//   per-frame valid flop masks entries that were never written.
// ----------------------------------------------------------------------------
module page_frame_allocator_fifo_random
  import pfa_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  pfa_req_t       in_req,
  output logic           out_valid,
  output pfa_res_t       out_res,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [SEED_BITS-1:0] cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_FIND, ST_OUT} state_t;

  state_t                state_r, state_nxt;
  pfa_req_t              req_r, req_nxt;
  logic [FRAME_BITS-1:0] f_r, f_nxt;
  logic                  found_r, found_nxt;
  logic                  old_valid_r, old_valid_nxt;
  logic                  old_dirty_r, old_dirty_nxt;
  logic [NUM_FRAMES-1:0] free_r, free_nxt;
  logic [NUM_FRAMES-1:0] valid_r, valid_nxt;
  logic [NUM_FRAMES-1:0] dirty_r, dirty_nxt;
  logic [FRAME_BITS-1:0] head_r, head_nxt;
  logic [FRAME_BITS:0]   count_r, count_nxt;
  logic [SEED_BITS-1:0]  lfsr_r, lfsr_nxt;
  logic [1:0]            mode_r, mode_nxt;
  logic                  out_valid_r, out_valid_nxt;
  pfa_res_t              out_r, out_nxt;

  logic                  accept;
  logic                  pe_any;
  logic [FRAME_BITS-1:0] pe_idx;
  logic [SEED_BITS-1:0]  lfsr_adv;
  logic [FRAME_BITS-1:0] vic;
  logic                  hit;
  logic [1:0]            kind;

  // FIFO order memory
  logic                  fifo_we;
  logic [FRAME_BITS-1:0] fifo_waddr, fifo_wdata, fifo_rdata;

  // page table memory
  logic                  tbl_we;
  logic [FRAME_BITS-1:0] tbl_raddr;
  pfa_entry_t            tbl_wdata, tbl_rdata;

  assign accept    = start && !busy;
  assign busy      = (state_r == ST_FIND);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // lowest free frame
  always_comb begin
    pe_any = |free_r;
    pe_idx = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        pe_idx = FRAME_BITS'(i);
      end
    end
  end

  // Galois LFSR, right shift
  assign lfsr_adv = lfsr_r[0] ? ((lfsr_r >> 1) ^ LFSR_TAPS) : (lfsr_r >> 1);

  assign tbl_wdata = '{vpn: req_r.virtual_page, owner: req_r.process_id};

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    f_nxt         = f_r;
    found_nxt     = found_r;
    old_valid_nxt = old_valid_r;
    old_dirty_nxt = old_dirty_r;
    free_nxt      = free_r;
    valid_nxt     = valid_r;
    dirty_nxt     = dirty_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    lfsr_nxt      = lfsr_r;
    mode_nxt      = mode_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    fifo_we       = 1'b0;
    fifo_waddr    = head_r + count_r[FRAME_BITS-1:0];
    fifo_wdata    = '0;
    tbl_we        = 1'b0;
    tbl_raddr     = pe_idx;
    vic           = '0;
    hit           = 1'b0;
    kind          = FILL_ZERO;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt   = in_req;
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        // pick the frame and update the frame state flops; table read goes out now
        if (req_r.op == OP_DIRTY) begin
          f_nxt     = req_r.target_frame;
          found_nxt = ({1'b0, req_r.target_frame} < (FRAME_BITS+1)'(NUM_FRAMES));
          if (found_nxt) begin
            dirty_nxt[req_r.target_frame] = 1'b1;
          end
        end else begin
          priority if (pe_any) begin
            vic = pe_idx;
            hit = 1'b1;
            free_nxt[pe_idx] = 1'b0;
            if (mode_r == MODE_FIFO) begin
              fifo_we    = 1'b1;
              fifo_wdata = pe_idx;
              count_nxt  = count_r + (FRAME_BITS+1)'(1);
            end
          end else if (mode_r == MODE_FIFO && count_r != '0) begin
            // rotate head to tail: pop at head, push at head + count
            vic        = fifo_rdata;
            hit        = 1'b1;
            head_nxt   = head_r + FRAME_BITS'(1);
            fifo_we    = 1'b1;
            fifo_wdata = fifo_rdata;
          end else if (mode_r == MODE_RANDOM) begin
            vic      = lfsr_adv[FRAME_BITS-1:0];
            hit      = 1'b1;
            lfsr_nxt = lfsr_adv;
          end else begin
            hit = 1'b0;
          end
          tbl_raddr     = vic;
          f_nxt         = vic;
          found_nxt     = hit;
          old_valid_nxt = valid_r[vic];
          old_dirty_nxt = dirty_r[vic];
          if (hit) begin
            valid_nxt[vic] = 1'b1;
            dirty_nxt[vic] = 1'b0;
          end
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        out_nxt.status = !found_r;
        if (found_r) begin
          out_nxt.frame = f_r;
        end
        if (req_r.op == OP_FAULT && found_r) begin
          tbl_we = 1'b1;
          unique case (req_r.page_source)
            SRC_EXEC: kind = FILL_EXEC;
            SRC_SWAP: kind = FILL_SWAP;
            default:  kind = FILL_ZERO;
          endcase
          out_nxt.fill_kind = kind;
          if (kind != FILL_ZERO) begin
            out_nxt.fill_offset = req_r.file_offset;
          end
          if (old_valid_r) begin
            out_nxt.evicted       = 1'b1;
            out_nxt.evicted_page  = tbl_rdata.vpn;
            out_nxt.evicted_owner = tbl_rdata.owner;
            out_nxt.evicted_dirty = old_dirty_r;
          end
        end
        // back-to-back: a new request may be taken in this cycle
        if (accept) begin
          req_nxt   = in_req;
          state_nxt = ST_FIND;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE: mode_nxt = cfg_data[1:0];
        REG_SEED: lfsr_nxt = (cfg_data == '0) ? LFSR_ONE : cfg_data;
        default:  mode_nxt = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    f_r         <= f_nxt;
    found_r     <= found_nxt;
    old_valid_r <= old_valid_nxt;
    old_dirty_r <= old_dirty_nxt;
    out_r       <= out_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_r      <= '1;
      valid_r     <= '0;
      dirty_r     <= '0;
      head_r      <= '0;
      count_r     <= '0;
      lfsr_r      <= LFSR_ONE;
      mode_r      <= MODE_FIFO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      lfsr_r      <= lfsr_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // FIFO order: read always at the head; written only in FIND, whose read
  // data is never used, so no bypass is needed
  pfa_ram #(
    .WIDTH (FRAME_BITS),
    .DEPTH (NUM_FRAMES)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .raddr (head_r),
    .rdata (fifo_rdata)
  );

  // page table: read in FIND, written back in OUT
  pfa_ram #(
    .WIDTH ($bits(pfa_entry_t)),
    .DEPTH (NUM_FRAMES)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (f_r),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

`ifndef SYNTHESIS
  a_busy_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> ##1 out_valid)
    else $error("request in FIND did not produce a result beat");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy, 2))
    else $error("result beat without a request two cycles earlier");

  a_fifo_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FRAME_BITS+1)'(NUM_FRAMES))
    else $error("FIFO queue holds more frames than exist");
`endif

endmodule
